@@ design/utd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the UTF-8 to UTF-16 stream decoder.
package utd_pkg;

  // Result status codes as they leave on the output channel.
  typedef enum logic [2:0] {
    ST_UNIT     = 3'd0,
    ST_BAD_LEAD = 3'd1,
    ST_BAD_CONT = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_NO_MARK  = 3'd4
  } status_e;

  // Depth of the job queue between the front and back parts.
  localparam int unsigned JobDepth = 4;
  localparam int unsigned JobPtrW  = $clog2(JobDepth);
  localparam int unsigned JobCntW  = $clog2(JobDepth + 1);

  localparam logic [20:0] CpMax1      = 21'h00007F;
  localparam logic [20:0] CpMax2      = 21'h0007FF;
  localparam logic [20:0] CpMax3      = 21'h00FFFF;
  localparam logic [20:0] CpSurrLo    = 21'h00D800;
  localparam logic [20:0] CpSurrHi    = 21'h00DFFF;
  localparam logic [20:0] CpMaxUni    = 21'h10FFFF;
  localparam logic [19:0] SuppOffset  = 20'h10000;
  localparam logic [15:0] Replacement = 16'hFFFD;
  localparam logic [5:0]  HighSurrTag = 6'b110110;
  localparam logic [5:0]  LowSurrTag  = 6'b110111;

  // One unit of work handed from the front part to the back part.
  typedef struct packed {
    logic        is_err;
    status_e     status;
    logic [1:0]  seq_len;     // sequence length minus one
    logic [20:0] code_point;
  } utd_job_t;

  // Byte order mark, one byte per position.
  function automatic logic [7:0] bom_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'hEF;
      2'd1:    b = 8'hBB;
      2'd2:    b = 8'hBF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ design/utd_stream_if.sv @@
`timescale 1ns / 1ps
// Handshake channel interfaces for the byte input and the code unit output.
interface utd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       stream_start;
  logic       stream_end;

  modport source (output valid, output byte_in, output stream_start, output stream_end,
                  input ready);
  modport sink (input valid, input byte_in, input stream_start, input stream_end,
                output ready);
endinterface

interface utd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [2:0]  status;
  logic        run_last;

  modport source (output valid, output code_unit, output status, output run_last,
                  input ready);
  modport sink (input valid, input code_unit, input status, input run_last,
                output ready);
endinterface

@@ design/utf8_to_utf16_stream_decoder_unit.sv @@
`timescale 1ns / 1ps
// Top level of the UTF-8 to UTF-16 stream decoder.
//
//  Channel  Dir  Word contents
//  -------  ---  ---------------------------------------------------------
//  in_i     in   byte_in (8), stream_start (1), stream_end (1)
//  out_o    out  code_unit (16), status (3), run_last (1)
//
// One input word is taken per clock while the job queue has room; the front part decodes
// it in the cycle it is accepted.  While the output is ready, results leave one word per
// clock from the back part's output register, so a surrogate pair leaves as two words
// and a four-byte character therefore still drains in time.  Reset clears the decoder
// state, empties the queue and the output register.  A stalled output fills the
// four-entry queue, after which input ready falls.
module utf8_to_utf16_stream_decoder_unit
  import utd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  utd_in_if.sink    in_i,
  utd_out_if.source out_o
);

  logic     fifo_full;
  logic     accept;
  logic     job_valid;
  logic     job_push;
  utd_job_t job;
  logic     head_valid;
  utd_job_t head_job;
  logic     pop;

  // Words are taken whenever the queue has a free slot; a word may or may
  // not produce a job, so a free slot is always enough.
  assign in_i.ready = !fifo_full;
  assign accept     = in_i.valid && in_i.ready;
  assign job_push   = accept && job_valid;

  // The front part owns the byte order mark check and the partially built
  // code point.
  utd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (in_i.byte_in),
    .start_i     (in_i.stream_start),
    .end_i       (in_i.stream_end),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  // Jobs wait here so the front keeps running while the output is stalled.
  utd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (job_push),
    .push_job_i   (job),
    .full_o       (fifo_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  // The back part turns each job into one or two result words.
  utd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .code_unit_o  (out_o.code_unit),
    .status_o     (out_o.status),
    .run_last_o   (out_o.run_last)
  );

`ifndef SYNTHESIS
  // A job must never be pushed into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !fifo_full)
    else $error("job pushed into a full queue");

  // Error words carry a zero unit and always close their input word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_UNIT) |-> (out_o.code_unit == 16'd0 && out_o.run_last))
    else $error("error word with non-zero unit or open run");

  // A high surrogate is never the last word of its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_UNIT && out_o.code_unit[15:10] == HighSurrTag)
      |-> !out_o.run_last)
    else $error("high surrogate closes a run");

  // Once a high surrogate is taken, the low surrogate is presented next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.status == ST_UNIT &&
     out_o.code_unit[15:10] == HighSurrTag)
      |=> (out_o.valid && out_o.code_unit[15:10] == LowSurrTag && out_o.run_last))
    else $error("high surrogate not followed by low surrogate");
`endif

endmodule

@@ design/utd_front.sv @@
`timescale 1ns / 1ps
// Front part: tracks the byte order mark and sequence state, and issues jobs.
module utd_front
  import utd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       start_i,
  input  logic       end_i,
  output logic       job_valid_o,
  output utd_job_t   job_o
);

  logic [1:0]  mark_q, mark_d, mark_e;
  logic [1:0]  pend_q, pend_d, pend_e;
  logic [1:0]  len_q, len_d, len_e;
  logic [20:0] acc_q, acc_d, acc_e;
  logic        hold_q, hold_d, hold_e;

  // A stream start clears the state before the word is looked at.
  assign mark_e = start_i ? 2'd0  : mark_q;
  assign pend_e = start_i ? 2'd0  : pend_q;
  assign len_e  = start_i ? 2'd0  : len_q;
  assign acc_e  = start_i ? 21'd0 : acc_q;
  assign hold_e = start_i ? 1'b0  : hold_q;

  always_comb begin
    mark_d      = mark_e;
    pend_d      = pend_e;
    len_d       = len_e;
    acc_d       = acc_e;
    hold_d      = hold_e;
    job_valid_o = 1'b0;
    job_o       = '0;

    if (hold_e) begin
      job_valid_o = 1'b0;
    end else if (mark_e != 2'd3) begin
      if (byte_i != bom_byte(mark_e)) begin
        job_valid_o  = 1'b1;
        job_o.is_err = 1'b1;
        job_o.status = ST_NO_MARK;
        hold_d       = 1'b1;
      end else begin
        mark_d = mark_e + 2'd1;
        if (end_i && mark_d != 2'd3) begin
          job_valid_o  = 1'b1;
          job_o.is_err = 1'b1;
          job_o.status = ST_NO_MARK;
          hold_d       = 1'b1;
        end
      end
    end else if (pend_e == 2'd0) begin
      priority if (byte_i[7] == 1'b0) begin
        len_d            = 2'd0;
        job_valid_o      = 1'b1;
        job_o.status     = ST_UNIT;
        job_o.seq_len    = 2'd0;
        job_o.code_point = {13'd0, byte_i};
      end else if (byte_i[7:5] == 3'b110) begin
        acc_d  = {16'd0, byte_i[4:0]};
        pend_d = 2'd1;
        len_d  = 2'd1;
      end else if (byte_i[7:4] == 4'b1110) begin
        acc_d  = {17'd0, byte_i[3:0]};
        pend_d = 2'd2;
        len_d  = 2'd2;
      end else if (byte_i[7:3] == 5'b11110) begin
        acc_d  = {18'd0, byte_i[2:0]};
        pend_d = 2'd3;
        len_d  = 2'd3;
      end else begin
        job_valid_o  = 1'b1;
        job_o.is_err = 1'b1;
        job_o.status = ST_BAD_LEAD;
        hold_d       = 1'b1;
      end
      if (!job_valid_o && end_i && pend_d != 2'd0) begin
        job_valid_o  = 1'b1;
        job_o.is_err = 1'b1;
        job_o.status = ST_TRUNC;
        hold_d       = 1'b1;
      end
    end else begin
      if (byte_i[7:6] != 2'b10) begin
        job_valid_o  = 1'b1;
        job_o.is_err = 1'b1;
        job_o.status = ST_BAD_CONT;
        hold_d       = 1'b1;
      end else begin
        acc_d  = {acc_e[14:0], byte_i[5:0]};
        pend_d = pend_e - 2'd1;
        if (pend_d == 2'd0) begin
          job_valid_o      = 1'b1;
          job_o.status     = ST_UNIT;
          job_o.seq_len    = len_e;
          job_o.code_point = acc_d;
        end else if (end_i) begin
          job_valid_o  = 1'b1;
          job_o.is_err = 1'b1;
          job_o.status = ST_TRUNC;
          hold_d       = 1'b1;
        end
      end
    end

    // The last word of a stream returns everything to the reset state.
    if (end_i) begin
      mark_d = 2'd0;
      pend_d = 2'd0;
      len_d  = 2'd0;
      acc_d  = 21'd0;
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 2'd0;
      pend_q <= 2'd0;
      len_q  <= 2'd0;
      acc_q  <= 21'd0;
      hold_q <= 1'b0;
    end else if (accept_i) begin
      mark_q <= mark_d;
      pend_q <= pend_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
      hold_q <= hold_d;
    end
  end

endmodule

@@ design/utd_fifo.sv @@
`timescale 1ns / 1ps
// Short job queue between the front and back parts.
module utd_fifo
  import utd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  utd_job_t push_job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     head_valid_o,
  output utd_job_t head_job_o
);

  utd_job_t           mem_q [JobDepth];
  logic [JobPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [JobCntW-1:0] count_q;

  assign full_o       = (count_q == JobCntW'(JobDepth));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == JobPtrW'(JobDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == JobPtrW'(JobDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ design/utd_back.sv @@
`timescale 1ns / 1ps
// Back part: checks code points, splits surrogate pairs and drives the result register.
module utd_back
  import utd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  utd_job_t    head_job_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic [2:0]  status_o,
  output logic        run_last_o
);

  logic        valid_q;
  logic [15:0] unit_q, unit_d;
  status_e     status_q, status_d;
  logic        last_q, last_d;
  logic        second_q;
  logic        load_en;
  logic        bad_value;
  logic        is_pair;
  logic [19:0] supp_off;
  logic [20:0] cp;

  assign cp = head_job_i.code_point;

  always_comb begin
    bad_value = 1'b0;
    if (head_job_i.seq_len == 2'd1 && cp <= CpMax1) bad_value = 1'b1;
    if (head_job_i.seq_len == 2'd2 && cp <= CpMax2) bad_value = 1'b1;
    if (head_job_i.seq_len == 2'd3 && cp <= CpMax3) bad_value = 1'b1;
    if (cp >= CpSurrLo && cp <= CpSurrHi) bad_value = 1'b1;
    if (cp > CpMaxUni) bad_value = 1'b1;
  end

  assign is_pair  = !head_job_i.is_err && !bad_value && (cp > CpMax3);
  assign supp_off = cp[19:0] - SuppOffset;
  assign load_en  = !valid_q || out_ready_i;
  assign pop_o    = load_en && head_valid_i && !(is_pair && !second_q);

  always_comb begin
    last_d   = 1'b1;
    status_d = head_job_i.status;
    priority if (head_job_i.is_err) begin
      unit_d = 16'd0;
    end else if (bad_value) begin
      unit_d = Replacement;
    end else if (is_pair && !second_q) begin
      unit_d = {HighSurrTag, supp_off[19:10]};
      last_d = 1'b0;
    end else if (is_pair) begin
      unit_d = {LowSurrTag, cp[9:0]};
    end else begin
      unit_d = cp[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (load_en) begin
      valid_q <= head_valid_i;
      if (head_valid_i) begin
        second_q <= is_pair && !second_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en && head_valid_i) begin
      unit_q   <= unit_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign code_unit_o = unit_q;
  assign status_o    = status_q;
  assign run_last_o  = last_q;

endmodule
